@@ rtl/pf_pkg.sv @@
package pf_pkg;

  // width of the number to factor
  localparam int NUM_BITS = 31;
  // trial divisor width: covers sqrt of the largest number plus one step
  localparam int DIV_W = (NUM_BITS + 1) / 2 + 1;
  // divider bit counter width
  localparam int CNT_W = $clog2(NUM_BITS + 1);

  typedef logic [NUM_BITS-1:0] num_t;
  typedef logic [DIV_W-1:0]    dvs_t;

  localparam num_t NUM_TWO   = num_t'(2);
  localparam num_t NUM_ONE   = num_t'(1);
  localparam dvs_t DVS_TWO   = dvs_t'(2);
  localparam dvs_t DVS_THREE = dvs_t'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT_NONE,
    ST_TWOS,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_EMIT_D,
    ST_EMIT_REM
  } state_t;

  // which value goes into the output register
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_TWO,
    SEL_DIV,
    SEL_REM
  } emit_sel_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic num_small;
    logic rem_even;
    logic rem_is_two;
    logic div_done;
    logic q_lt_d;
    logic r_zero;
    logic slot_free;
  } stat_t;

  // controls from sequencer to datapath
  typedef struct packed {
    logic      in_take;
    logic      div_start;
    logic      d_step;
    logic      rem_shift;
    logic      rem_load_q;
    logic      emit;
    logic      emit_last;
    emit_sel_t emit_sel;
  } ctrl_t;

endpackage

@@ rtl/pf_divider.sv @@
module pf_divider
  import pf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  num_t dividend,
  input  dvs_t divisor,
  output logic done,
  output num_t quotient,
  output logic rem_zero
);

  num_t             quot;
  dvs_t             part;
  logic [CNT_W-1:0] cnt;
  logic             run;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    trial = {part, quot[NUM_BITS-1]};
    diff  = trial - {1'b0, divisor};
    fits  = (trial >= {1'b0, divisor});
  end

  // control: run flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(NUM_BITS);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      part <= '0;
    end else if (run) begin
      quot <= {quot[NUM_BITS-2:0], fits};
      part <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

  assign quotient = quot;
  assign rem_zero = (part == '0);

endmodule

@@ rtl/pf_ctrl.sv @@
module pf_ctrl
  import pf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t st,
  output ctrl_t ctl,
  output logic  idle
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (st.in_valid) begin
          state_next = st.num_small ? ST_EMIT_NONE : ST_TWOS;
        end
      end
      ST_EMIT_NONE: begin
        if (st.slot_free) state_next = ST_IDLE;
      end
      ST_TWOS: begin
        if (!st.rem_even) begin
          state_next = ST_DIV_START;
        end else if (st.slot_free && st.rem_is_two) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV_START: begin
        state_next = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (st.div_done) begin
          if (st.q_lt_d) begin
            state_next = ST_EMIT_REM;
          end else if (st.r_zero) begin
            state_next = ST_EMIT_D;
          end else begin
            state_next = ST_DIV_START;
          end
        end
      end
      ST_EMIT_D: begin
        if (st.slot_free) state_next = ST_DIV_START;
      end
      ST_EMIT_REM: begin
        if (st.slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl  = '0;
    idle = 1'b0;
    unique case (state)
      ST_IDLE: begin
        idle        = 1'b1;
        ctl.in_take = st.in_valid;
      end
      ST_EMIT_NONE: begin
        ctl.emit      = st.slot_free;
        ctl.emit_last = 1'b1;
        ctl.emit_sel  = SEL_NONE;
      end
      ST_TWOS: begin
        if (st.rem_even && st.slot_free) begin
          ctl.emit      = 1'b1;
          ctl.emit_last = st.rem_is_two;
          ctl.emit_sel  = SEL_TWO;
          ctl.rem_shift = 1'b1;
        end
      end
      ST_DIV_START: begin
        ctl.div_start = 1'b1;
      end
      ST_DIV_RUN: begin
        ctl.d_step = st.div_done && !st.q_lt_d && !st.r_zero;
      end
      ST_EMIT_D: begin
        if (st.slot_free) begin
          ctl.emit       = 1'b1;
          ctl.emit_sel   = SEL_DIV;
          ctl.rem_load_q = 1'b1;
        end
      end
      ST_EMIT_REM: begin
        ctl.emit      = st.slot_free;
        ctl.emit_last = 1'b1;
        ctl.emit_sel  = SEL_REM;
      end
      default: begin
        idle = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/prime_factorizer.sv @@
// channel | handshake            | payload
// --------+----------------------+-------------------------------
// input   | in_valid / in_stall  | number
// output  | out_valid / out_stall| factor, last, no_factors
//
// one item at a time; in_stall is high from acceptance until the last result
// is loaded into the output register. factors of 2 are shifted out one by one,
// each when the output slot is free; every odd trial divisor costs at least one
// pass of the shared bit-serial divider, plus one more for each factor it yields.
// rst is synchronous and returns the sequencer to idle with no result pending.
// a stalled output freezes the sequencer at its next result.
module prime_factorizer
  import pf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  num_t number,
  output logic out_valid,
  input  logic out_stall,
  output num_t factor,
  output logic last,
  output logic no_factors
);

  num_t  rem;
  dvs_t  dvs;
  stat_t st;
  ctrl_t ctl;
  logic  idle;
  logic  div_done;
  num_t  quotient;
  logic  rem_zero;

  pf_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (rem),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quotient),
    .rem_zero (rem_zero)
  );

  pf_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .st   (st),
    .ctl  (ctl),
    .idle (idle)
  );

  assign in_stall = !idle;

  // status to the sequencer
  always_comb begin
    st.in_valid   = in_valid;
    st.num_small  = (number < NUM_TWO);
    st.rem_even   = !rem[0];
    st.rem_is_two = (rem == NUM_TWO);
    st.div_done   = div_done;
    st.q_lt_d     = (quotient < num_t'(dvs));
    st.r_zero     = rem_zero;
    st.slot_free  = !out_valid || !out_stall;
  end

  // remainder and trial divisor
  always_ff @(posedge clk) begin
    if (ctl.in_take) begin
      rem <= number;
      dvs <= DVS_THREE;
    end else begin
      if (ctl.rem_shift)  rem <= rem >> 1;
      if (ctl.rem_load_q) rem <= quotient;
      if (ctl.d_step)     dvs <= dvs + DVS_TWO;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      last       <= ctl.emit_last;
      no_factors <= (ctl.emit_sel == SEL_NONE);
      case (ctl.emit_sel)
        SEL_TWO: factor <= NUM_TWO;
        SEL_DIV: factor <= num_t'(dvs);
        SEL_REM: factor <= rem;
        default: factor <= '0;
      endcase
    end
  end

endmodule

@@ tb/factor_checker.sv @@
`timescale 1ns / 1ps
module factor_checker
  import pf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  num_t number,
  input  logic out_valid,
  input  logic out_stall,
  input  num_t factor,
  input  logic last,
  input  logic no_factors,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    num_t factor;
    logic last;
    logic no_factors;
  } factor_result_t;

  // factors still owed by the block, oldest first
  factor_result_t expected_factors[$];

  // trial division: twos first, then odd divisors until d*d passes the cofactor
  function automatic void predict_factors(input num_t n);
    logic [63:0]    rem;
    logic [63:0]    d;
    num_t           primes[$];
    factor_result_t r;
    rem = 64'(n);
    if (rem < 64'd2) begin
      r.factor     = '0;
      r.last       = 1'b1;
      r.no_factors = 1'b1;
      expected_factors.push_back(r);
      return;
    end
    while (rem[0] == 1'b0) begin
      primes.push_back(NUM_TWO);
      rem = rem >> 1;
    end
    d = 64'd3;
    while (d * d <= rem) begin
      while (rem % d == 64'd0) begin
        primes.push_back(num_t'(d));
        rem = rem / d;
      end
      d = d + 64'd2;
    end
    // leftover cofactor is the largest prime
    if (rem > 64'd1) primes.push_back(num_t'(rem));
    foreach (primes[i]) begin
      r.factor     = primes[i];
      r.last       = (i == primes.size() - 1);
      r.no_factors = 1'b0;
      expected_factors.push_back(r);
    end
  endfunction

  // watch both channels, predict on input, compare on output
  always @(posedge clk) begin
    factor_result_t want;
    if (rst) begin
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) predict_factors(number);
      if (out_valid && !out_stall) begin
        if (expected_factors.size() == 0) begin
          $error("result with no item pending: factor %0d last %0b no_factors %0b",
                 factor, last, no_factors);
          fail_count = fail_count + 1;
        end else begin
          want = expected_factors.pop_front();
          if (factor !== want.factor) begin
            $error("factor mismatch: expected %0d, actual %0d", want.factor, factor);
            fail_count = fail_count + 1;
          end
          if (last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, last);
            fail_count = fail_count + 1;
          end
          if (no_factors !== want.no_factors) begin
            $error("no_factors mismatch: expected %0b, actual %0b",
                   want.no_factors, no_factors);
            fail_count = fail_count + 1;
          end
        end
      end
      pending <= expected_factors.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top
  import pf_pkg::*;
();

  localparam int RANDOM_ITEMS = 80;
  localparam int HOLD_AT      = 40;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 200;

  logic clk        = 1'b0;
  logic rst        = 1'b1;
  logic in_valid   = 1'b0;
  logic in_stall;
  num_t number     = '0;
  logic out_valid;
  logic out_stall  = 1'b0;
  num_t factor;
  logic last;
  logic no_factors;

  int   fail_count;
  int   pending;
  bit   quiet = 1'b0;

  num_t directed_nums[$];
  int   small_primes [25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
                              53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

  always #1 clk = ~clk;

  prime_factorizer DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .number     (number),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .factor     (factor),
    .last       (last),
    .no_factors (no_factors)
  );

  factor_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .number     (number),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .factor     (factor),
    .last       (last),
    .no_factors (no_factors),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // offer one number after a random gap and hold it until taken
  task automatic send_number(input num_t n);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    number   <= n;
    do @(posedge clk); while (in_stall);
  endtask

  // result side: random stalls, one long hold-off to back up the input
  initial begin : receiver
    int stall_cycles;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      stall_cycles = quiet ? 0 : $urandom_range(0, 11);
      if (taken == HOLD_AT) begin
        out_stall <= 1'b1;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
      end else if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    num_t            n;
    longint unsigned prod;
    longint unsigned ceiling;
    int              misses;
    int              q;
    int              pick;
    directed_nums = '{
      31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd6, 31'd9, 31'd24, 31'd25, 31'd49,
      31'd315, 31'd64507, 31'd65521, 31'd131042, 31'd16777213, 31'd16752649,
      31'd1073741824, 31'd1162261467, 31'd2138046464, 31'd2147483646,
      31'd223092870
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: zero and one, primes, squares, all twos, wide values
    foreach (directed_nums[i]) send_number(directed_nums[i]);

    // random: mostly small numbers, wide ones built from small primes
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 50 && i < 70);
      pick  = $urandom_range(0, 99);
      if (pick < 10) begin
        n = num_t'($urandom_range(0, 3));
      end else if (pick < 50) begin
        n = num_t'($urandom_range(0, 4095));
      end else if (pick < 65) begin
        n = num_t'($urandom_range(0, 262143));
      end else begin
        ceiling = 64'd1 << $urandom_range(20, 31);
        prod    = 1;
        misses  = 0;
        while (misses < 4) begin
          q = small_primes[$urandom_range(0, 24)];
          if (prod * q < ceiling) prod = prod * q;
          else misses++;
        end
        n = num_t'(prod);
      end
      send_number(n);
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pf_pkg.sv
rtl/pf_divider.sv
rtl/pf_ctrl.sv
rtl/prime_factorizer.sv
tb/factor_checker.sv
tb/tb_top.sv
